[hdl/dsc_pkg.sv]
// shared constants, types and helper functions of the pairwise substitution counter
// no dependencies; compile first
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

   localparam int BASES_W           = 64;
   localparam int CHAR_W            = 8;
   localparam int CFG_W             = 4;
   localparam int IDX_W             = 3;
   localparam int COUNT_W           = 17;
   localparam int COUNT_MAX         = 131071;
   localparam int DEF_MAX_SEQUENCES = 8;
   localparam int DEF_MAX_SITES     = 65536;

   localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_C = 8'h63;
   localparam logic [CHAR_W-1:0] CHAR_G = 8'h67;
   localparam logic [CHAR_W-1:0] CHAR_T = 8'h74;

   // per pair counter set handed from a lane to the drain stage
   typedef struct packed {
      logic [COUNT_W-1:0] transition;
      logic [COUNT_W-1:0] transversion;
      logic [COUNT_W-1:0] common;
   } pair_counts_type;

   function automatic logic base_ok(input logic [CHAR_W-1:0] ch);
      return (ch == CHAR_A) || (ch == CHAR_C) || (ch == CHAR_G) || (ch == CHAR_T);
   endfunction

   function automatic logic is_transition(input logic [CHAR_W-1:0] x,
                                          input logic [CHAR_W-1:0] y);
      return ((x == CHAR_A) && (y == CHAR_G)) || ((x == CHAR_G) && (y == CHAR_A)) ||
             ((x == CHAR_C) && (y == CHAR_T)) || ((x == CHAR_T) && (y == CHAR_C));
   endfunction

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v,
                                                  input logic [COUNT_W-1:0] limit);
      return (v < limit) ? v + 1'b1 : limit;
   endfunction

endpackage

`default_nettype wire

[hdl/dsc_if.sv]
// channel interfaces: column input, pair result output, sequence count register write
// depends on dsc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface dsc_req_if
   import dsc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [BASES_W-1:0] site_bases;
   logic               last_site;

   modport source (output valid, site_bases, last_site, input ready);
   modport sink   (input valid, site_bases, last_site, output ready);
endinterface

interface dsc_rsp_if
   import dsc_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   row_index;
   logic [IDX_W-1:0]   col_index;
   logic [COUNT_W-1:0] transition_count;
   logic [COUNT_W-1:0] transversion_count;
   logic [COUNT_W-1:0] common_sites;
   logic               last_result;

   modport source (output valid, row_index, col_index, transition_count,
                   transversion_count, common_sites, last_result, input ready);
   modport sink   (input valid, row_index, col_index, transition_count,
                   transversion_count, common_sites, last_result, output ready);
endinterface

interface dsc_csr_if
   import dsc_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hdl/dsc_pair_lane.sv]
// one pair lane: classifies the two bytes of its sequences and keeps three saturating counters
// depends on dsc_pkg
`timescale 1ns / 1ps
`default_nettype none

module dsc_pair_lane
   import dsc_pkg::*;
#(
   parameter int ROW_SEQ   = 0,
   parameter int COL_SEQ   = 1,
   parameter int MAX_SITES = DEF_MAX_SITES,
   parameter int SEQ_CNT_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 update,
   input  wire logic                 clear,
   input  wire logic [BASES_W-1:0]   site_bases,
   input  wire logic [SEQ_CNT_W-1:0] seq_count,
   output pair_counts_type           counts
);

   localparam int CntLimit = (MAX_SITES > COUNT_MAX) ? COUNT_MAX : MAX_SITES;
   localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(CntLimit);

   logic [CHAR_W-1:0] ch_x;
   logic [CHAR_W-1:0] ch_y;
   logic              active;
   logic              both_ok;
   pair_counts_type   counts_ff;
   pair_counts_type   counts_in;

   assign ch_x    = site_bases[CHAR_W*ROW_SEQ +: CHAR_W];
   assign ch_y    = site_bases[CHAR_W*COL_SEQ +: CHAR_W];
   assign active  = SEQ_CNT_W'(COL_SEQ) < seq_count;
   assign both_ok = base_ok(ch_x) && base_ok(ch_y);

   always_comb begin
      counts_in = counts_ff;
      if (clear) begin
         counts_in = '0;
      end else if (update && active && both_ok) begin
         counts_in.common = sat_inc(counts_ff.common, LIMIT);
         if (ch_x != ch_y) begin
            if (is_transition(ch_x, ch_y)) begin
               counts_in.transition = sat_inc(counts_ff.transition, LIMIT);
            end else begin
               counts_in.transversion = sat_inc(counts_ff.transversion, LIMIT);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff <= '0;
      end else begin
         counts_ff <= counts_in;
      end
   end

   assign counts = counts_ff;

endmodule

`default_nettype wire

[hdl/dsc_drain.sv]
// merging stage: site total, triangle walk over the lane counters and the result register
// depends on dsc_pkg and dsc_rsp_if
`timescale 1ns / 1ps
`default_nettype none

module dsc_drain
   import dsc_pkg::*;
#(
   parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES,
   parameter int MAX_SITES     = DEF_MAX_SITES,
   parameter int SEQ_W         = 3,
   parameter int SEQ_CNT_W     = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 accept_last,
   input  wire logic [SEQ_CNT_W-1:0] seq_count,
   input  pair_counts_type           counts [MAX_SEQUENCES][MAX_SEQUENCES],
   output logic                      busy,
   output logic                      clear,
   dsc_rsp_if.source                 rsp
);

   localparam int CntLimit = (MAX_SITES > COUNT_MAX) ? COUNT_MAX : MAX_SITES;
   localparam logic [COUNT_W-1:0] LIMIT = COUNT_W'(CntLimit);

   typedef enum logic {ST_IDLE, ST_DRAIN} state_type;

   state_type          state_ff;
   logic [SEQ_W-1:0]   row_ff;
   logic [SEQ_W-1:0]   col_ff;
   logic [SEQ_W-1:0]   last_idx_ff;
   logic [COUNT_W-1:0] site_total_ff;
   logic               out_valid_ff;
   logic [IDX_W-1:0]   out_row_ff;
   logic [IDX_W-1:0]   out_col_ff;
   logic [COUNT_W-1:0] out_ts_ff;
   logic [COUNT_W-1:0] out_tv_ff;
   logic [COUNT_W-1:0] out_common_ff;
   logic               out_last_ff;

   pair_counts_type    sel;
   logic               slot_free;
   logic               emit;
   logic               final_pair;
   logic               diag;

   assign sel        = counts[row_ff][col_ff];
   assign slot_free  = !out_valid_ff || rsp.ready;
   assign emit       = (state_ff == ST_DRAIN) && slot_free;
   assign final_pair = (row_ff == last_idx_ff) && (col_ff == last_idx_ff);
   assign diag       = row_ff == col_ff;
   assign clear      = emit && final_pair;
   assign busy       = state_ff == ST_DRAIN;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         site_total_ff <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         last_idx_ff   <= '0;
      end else begin
         if (clear) begin
            site_total_ff <= '0;
         end else if (accept) begin
            site_total_ff <= sat_inc(site_total_ff, LIMIT);
         end

         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept && accept_last) begin
                  state_ff    <= ST_DRAIN;
                  row_ff      <= '0;
                  col_ff      <= '0;
                  last_idx_ff <= SEQ_W'(seq_count - 1'b1);
               end
            end
            ST_DRAIN: begin
               if (emit) begin
                  if (final_pair) begin
                     state_ff <= ST_IDLE;
                  end else if (col_ff == last_idx_ff) begin
                     // next row starts on its diagonal
                     row_ff <= row_ff + 1'b1;
                     col_ff <= row_ff + 1'b1;
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (emit) begin
         out_row_ff    <= IDX_W'(row_ff);
         out_col_ff    <= IDX_W'(col_ff);
         out_ts_ff     <= diag ? '0 : sel.transition;
         out_tv_ff     <= diag ? '0 : sel.transversion;
         out_common_ff <= diag ? site_total_ff : sel.common;
         out_last_ff   <= final_pair;
      end
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.row_index          = out_row_ff;
   assign rsp.col_index          = out_col_ff;
   assign rsp.transition_count   = out_ts_ff;
   assign rsp.transversion_count = out_tv_ff;
   assign rsp.common_sites       = out_common_ff;
   assign rsp.last_result        = out_last_ff;

endmodule

`default_nettype wire

[hdl/pairwise_dna_substitution_counter.sv]
// top level of the pairwise dna substitution counter: pair lanes, drain stage, register
// depends on dsc_pkg, dsc_if, dsc_pair_lane and dsc_drain
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | beat payload                                      | accepted when
// ---------+-----+---------------------------------------------------+-------------------
// req_bus  | in  | site_bases (64), last_site (1)                    | valid && ready
// rsp_bus  | out | row/col index (3+3), three counts (17 each), last | valid && ready
// csr_bus  | in  | data (4) = num_sequences                          | valid && ready
//
// one column beat per cycle outside the drain: every pair lane in use updates its counters in the beat's cycle
// a last column starts the drain: one result per cycle while rsp_bus takes them,
//   n*(n+1)/2 results for n sequences in use, all through the single result register
// req_bus ready is low during the drain; counters clear on the cycle of the final result
// synchronous active-high reset clears all counters and sets num_sequences to 8
// csr_bus is always ready; write it only while the block is idle

module pairwise_dna_substitution_counter
   import dsc_pkg::*;
#(
   parameter int MAX_SEQUENCES = DEF_MAX_SEQUENCES,
   parameter int MAX_SITES     = DEF_MAX_SITES
) (
   input  wire logic clock,
   input  wire logic reset,
   dsc_req_if.sink   req_bus,
   dsc_rsp_if.source rsp_bus,
   dsc_csr_if.sink   csr_bus
);

   // index bits for one sequence, and bits for a count of sequences
   localparam int SEQ_W     = $clog2(MAX_SEQUENCES);
   localparam int SEQ_CNT_W = $clog2(MAX_SEQUENCES + 1);

   logic [CFG_W-1:0]     num_sequences_ff;
   logic [SEQ_CNT_W-1:0] seq_count;
   logic                 accept;
   logic                 busy;
   logic                 clear;
   pair_counts_type      counts [MAX_SEQUENCES][MAX_SEQUENCES];

   // sequence count register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_sequences_ff <= CFG_W'(DEF_MAX_SEQUENCES);
      end else if (csr_bus.valid) begin
         num_sequences_ff <= csr_bus.data;
      end
   end

   // zero acts as one, anything above the lane count as the lane count
   always_comb begin
      if (num_sequences_ff == '0) begin
         seq_count = SEQ_CNT_W'(1);
      end else if (32'(num_sequences_ff) > MAX_SEQUENCES) begin
         seq_count = SEQ_CNT_W'(MAX_SEQUENCES);
      end else begin
         seq_count = SEQ_CNT_W'(num_sequences_ff);
      end
   end

   // column intake, held off while the triangle drains
   assign req_bus.ready = !busy;
   assign accept        = req_bus.valid && !busy;

   // one lane per pair above the diagonal
   for (genvar gi = 0; gi < MAX_SEQUENCES; gi++) begin : g_row
      for (genvar gj = 0; gj < MAX_SEQUENCES; gj++) begin : g_col
         if (gi < gj) begin : g_lane
            dsc_pair_lane #(
               .ROW_SEQ   (gi),
               .COL_SEQ   (gj),
               .MAX_SITES (MAX_SITES),
               .SEQ_CNT_W (SEQ_CNT_W)
            ) u_lane (
               .clock      (clock),
               .reset      (reset),
               .update     (accept),
               .clear      (clear),
               .site_bases (req_bus.site_bases),
               .seq_count  (seq_count),
               .counts     (counts[gi][gj])
            );
         end else begin : g_none
            // diagonal and lower half carry no counters
            assign counts[gi][gj] = '0;
         end
      end
   end

   // merge: walk the triangle row by row and register each result
   dsc_drain #(
      .MAX_SEQUENCES (MAX_SEQUENCES),
      .MAX_SITES     (MAX_SITES),
      .SEQ_W         (SEQ_W),
      .SEQ_CNT_W     (SEQ_CNT_W)
   ) u_drain (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .accept_last (req_bus.last_site),
      .seq_count   (seq_count),
      .counts      (counts),
      .busy        (busy),
      .clear       (clear),
      .rsp         (rsp_bus)
   );

endmodule

`default_nettype wire
